// ===== design/mcrb_pkg.sv =====
// Package with the word map, reset values, write masks and shared types of the register bank.
package mcrb_pkg;

  localparam int unsigned WindowBytesDefault = 16384;
  localparam int unsigned OffsetWidth        = 14;
  localparam int unsigned SizeWidth          = 4;
  localparam int unsigned DataWidth          = 32;
  localparam int unsigned WordWidth          = 5;

  localparam logic [SizeWidth-1:0] ACCESS_WORD_BYTES = 4'd4;

  // Word indexes within the window.
  localparam logic [WordWidth-1:0] WORD_SDRAM_CFG    = 5'd0;
  localparam logic [WordWidth-1:0] WORD_REFRESH_CFG  = 5'd1;
  localparam logic [WordWidth-1:0] WORD_STATIC_TIM0  = 5'd2;
  localparam logic [WordWidth-1:0] WORD_STATIC_TIM1  = 5'd3;
  localparam logic [WordWidth-1:0] WORD_STATIC_TIM2  = 5'd4;
  localparam logic [WordWidth-1:0] WORD_EXP_CFG      = 5'd5;
  localparam logic [WordWidth-1:0] WORD_SYNC_STATIC  = 5'd7;
  localparam logic [WordWidth-1:0] WORD_UNDOC        = 5'd8;
  localparam logic [WordWidth-1:0] WORD_SYNC_MODE    = 5'd9;
  localparam logic [WordWidth-1:0] WORD_CARD_TIM0    = 5'd10;
  localparam logic [WordWidth-1:0] WORD_CARD_TIM1    = 5'd11;
  localparam logic [WordWidth-1:0] WORD_CARD_TIM2    = 5'd12;
  localparam logic [WordWidth-1:0] WORD_CARD_TIM3    = 5'd13;
  localparam logic [WordWidth-1:0] WORD_CARD_TIM4    = 5'd14;
  localparam logic [WordWidth-1:0] WORD_CARD_TIM5    = 5'd15;
  localparam logic [WordWidth-1:0] WORD_MODE         = 5'd16;
  localparam logic [WordWidth-1:0] WORD_BOOT         = 5'd17;
  localparam logic [WordWidth-1:0] WORD_ARBITER      = 5'd18;
  localparam logic [WordWidth-1:0] WORD_BUF_STR0     = 5'd19;
  localparam logic [WordWidth-1:0] WORD_BUF_STR1     = 5'd20;
  localparam logic [WordWidth-1:0] WORD_LCD_BUF_STR  = 5'd21;
  localparam logic [WordWidth-1:0] WORD_LOW_PWR_MODE = 5'd22;
  localparam logic [WordWidth-1:0] WORD_BUF_STR2     = 5'd23;
  localparam logic [WordWidth-1:0] WORD_BUF_STR3     = 5'd24;
  localparam logic [WordWidth-1:0] WORD_COMPANION    = 5'd25;

  localparam int unsigned LcdWidth  = 4;
  localparam int unsigned CompWidth = 14;

  localparam logic [DataWidth-1:0] BOOT_WORD_VALUE = 32'd9;
  localparam logic [DataWidth-1:0] ARB_WRITE_MASK  = 32'hff80_0fff;
  localparam logic [LcdWidth-1:0]  LCD_WRITE_MASK  = 4'hf;
  localparam logic [CompWidth-1:0] COMP_WRITE_MASK = 14'h313f;

  localparam logic [DataWidth-1:0] SDRAM_CFG_RESET   = 32'h0b00_0b00;
  localparam logic [DataWidth-1:0] REFRESH_CFG_RESET = 32'h23ca_4fff;
  localparam logic [DataWidth-1:0] STATIC_TIM_RESET  = 32'h7ff0_7ff0;
  localparam logic [DataWidth-1:0] SYNC_STATIC_RESET = 32'h4004_4004;
  localparam logic [DataWidth-1:0] MODE_RESET        = 32'h0022_0022;
  localparam logic [DataWidth-1:0] ARBITER_RESET     = 32'h0080_0234;
  localparam logic [DataWidth-1:0] BUF_STR_RESET     = 32'h5555_5555;
  localparam logic [LcdWidth-1:0]  LCD_BUF_STR_RESET = 4'd5;

  // Result of decoding one access.
  typedef struct packed {
    logic                 ok;
    logic                 wr_en;
    logic [WordWidth-1:0] word;
  } dec_t;

endpackage

// ===== design/mcrb_decode.sv =====
// Access decoder: checks size, window and word map, and picks the target word.
module mcrb_decode
  import mcrb_pkg::*;
#(
  parameter int unsigned WINDOW_BYTES = WindowBytesDefault
) (
  input  logic                   func,
  input  logic [OffsetWidth-1:0] byte_offset,
  input  logic [SizeWidth-1:0]   access_bytes,
  input  logic                   gen2,
  output dec_t                   dec
);

  localparam logic [OffsetWidth+2:0] WindowLimit = (OffsetWidth + 3)'(WINDOW_BYTES);

  logic                 in_window;
  logic                 high_zero;
  logic [WordWidth-1:0] word;
  logic                 mapped;

  assign in_window = ({3'b000, byte_offset} < WindowLimit) &&
                     (access_bytes == ACCESS_WORD_BYTES);
  assign word      = byte_offset[WordWidth+1:2];
  // Every mapped word lies in the first 32 words of the window.
  assign high_zero = (byte_offset[OffsetWidth-1:WordWidth+2] == '0);

  always_comb begin
    mapped = 1'b0;
    if (word inside {WORD_SDRAM_CFG, WORD_REFRESH_CFG, WORD_STATIC_TIM0,
                     WORD_STATIC_TIM1, WORD_STATIC_TIM2, WORD_EXP_CFG,
                     WORD_SYNC_STATIC, [WORD_CARD_TIM0:WORD_CARD_TIM5],
                     WORD_MODE, WORD_LOW_PWR_MODE, WORD_COMPANION}) begin
      mapped = 1'b1;
    end else if (word inside {WORD_UNDOC, WORD_ARBITER, WORD_BUF_STR0, WORD_BUF_STR1,
                              WORD_LCD_BUF_STR, WORD_BUF_STR2, WORD_BUF_STR3}) begin
      mapped = gen2;
    end else if (word == WORD_SYNC_MODE) begin
      mapped = !gen2;
    end else if (word == WORD_BOOT) begin
      // The boot word is read-only; a write to it is a bus error.
      mapped = !func;
    end
  end

  assign dec.ok    = in_window && high_zero && mapped;
  assign dec.wr_en = in_window && high_zero && mapped && func;
  assign dec.word  = word;

endmodule

// ===== design/mcrb_regfile.sv =====
// Storage of the controller words with masked writes and a read multiplexer.
module mcrb_regfile
  import mcrb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [WordWidth-1:0] word,
  input  logic [DataWidth-1:0] wr_data,
  output logic [DataWidth-1:0] rd_data
);

  logic [DataWidth-1:0] sdram_cfg_r;
  logic [DataWidth-1:0] refresh_cfg_r;
  logic [DataWidth-1:0] static_tim0_r;
  logic [DataWidth-1:0] static_tim1_r;
  logic [DataWidth-1:0] static_tim2_r;
  logic [DataWidth-1:0] exp_cfg_r;
  logic [DataWidth-1:0] sync_static_r;
  logic [DataWidth-1:0] undoc_r;
  logic [DataWidth-1:0] sync_mode_r;
  logic [DataWidth-1:0] card_tim0_r;
  logic [DataWidth-1:0] card_tim1_r;
  logic [DataWidth-1:0] card_tim2_r;
  logic [DataWidth-1:0] card_tim3_r;
  logic [DataWidth-1:0] card_tim4_r;
  logic [DataWidth-1:0] card_tim5_r;
  logic [DataWidth-1:0] mode_r;
  logic [DataWidth-1:0] arbiter_r;
  logic [DataWidth-1:0] buf_str0_r;
  logic [DataWidth-1:0] buf_str1_r;
  logic [DataWidth-1:0] buf_str2_r;
  logic [DataWidth-1:0] buf_str3_r;
  logic [LcdWidth-1:0]  lcd_buf_str_r;
  logic [DataWidth-1:0] low_pwr_mode_r;
  logic [CompWidth-1:0] companion_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sdram_cfg_r    <= SDRAM_CFG_RESET;
      refresh_cfg_r  <= REFRESH_CFG_RESET;
      static_tim0_r  <= STATIC_TIM_RESET;
      static_tim1_r  <= STATIC_TIM_RESET;
      static_tim2_r  <= STATIC_TIM_RESET;
      exp_cfg_r      <= '0;
      sync_static_r  <= SYNC_STATIC_RESET;
      undoc_r        <= '0;
      sync_mode_r    <= '0;
      card_tim0_r    <= '0;
      card_tim1_r    <= '0;
      card_tim2_r    <= '0;
      card_tim3_r    <= '0;
      card_tim4_r    <= '0;
      card_tim5_r    <= '0;
      mode_r         <= MODE_RESET;
      arbiter_r      <= ARBITER_RESET;
      buf_str0_r     <= BUF_STR_RESET;
      buf_str1_r     <= BUF_STR_RESET;
      buf_str2_r     <= BUF_STR_RESET;
      buf_str3_r     <= BUF_STR_RESET;
      lcd_buf_str_r  <= LCD_BUF_STR_RESET;
      low_pwr_mode_r <= '0;
      companion_r    <= '0;
    end else if (wr_en) begin
      case (word)
        WORD_SDRAM_CFG:    sdram_cfg_r    <= wr_data;
        WORD_REFRESH_CFG:  refresh_cfg_r  <= wr_data;
        WORD_STATIC_TIM0:  static_tim0_r  <= wr_data;
        WORD_STATIC_TIM1:  static_tim1_r  <= wr_data;
        WORD_STATIC_TIM2:  static_tim2_r  <= wr_data;
        WORD_EXP_CFG:      exp_cfg_r      <= wr_data;
        WORD_SYNC_STATIC:  sync_static_r  <= wr_data;
        WORD_UNDOC:        undoc_r        <= wr_data;
        WORD_SYNC_MODE:    sync_mode_r    <= wr_data;
        WORD_CARD_TIM0:    card_tim0_r    <= wr_data;
        WORD_CARD_TIM1:    card_tim1_r    <= wr_data;
        WORD_CARD_TIM2:    card_tim2_r    <= wr_data;
        WORD_CARD_TIM3:    card_tim3_r    <= wr_data;
        WORD_CARD_TIM4:    card_tim4_r    <= wr_data;
        WORD_CARD_TIM5:    card_tim5_r    <= wr_data;
        WORD_MODE:         mode_r         <= wr_data;
        WORD_ARBITER:      arbiter_r      <= wr_data & ARB_WRITE_MASK;
        WORD_BUF_STR0:     buf_str0_r     <= wr_data;
        WORD_BUF_STR1:     buf_str1_r     <= wr_data;
        WORD_LCD_BUF_STR:  lcd_buf_str_r  <= wr_data[LcdWidth-1:0] & LCD_WRITE_MASK;
        WORD_LOW_PWR_MODE: low_pwr_mode_r <= wr_data;
        WORD_BUF_STR2:     buf_str2_r     <= wr_data;
        WORD_BUF_STR3:     buf_str3_r     <= wr_data;
        WORD_COMPANION:    companion_r    <= wr_data[CompWidth-1:0] & COMP_WRITE_MASK;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (word)
      WORD_SDRAM_CFG:    rd_data = sdram_cfg_r;
      WORD_REFRESH_CFG:  rd_data = refresh_cfg_r;
      WORD_STATIC_TIM0:  rd_data = static_tim0_r;
      WORD_STATIC_TIM1:  rd_data = static_tim1_r;
      WORD_STATIC_TIM2:  rd_data = static_tim2_r;
      WORD_EXP_CFG:      rd_data = exp_cfg_r;
      WORD_SYNC_STATIC:  rd_data = sync_static_r;
      WORD_UNDOC:        rd_data = undoc_r;
      WORD_SYNC_MODE:    rd_data = sync_mode_r;
      WORD_CARD_TIM0:    rd_data = card_tim0_r;
      WORD_CARD_TIM1:    rd_data = card_tim1_r;
      WORD_CARD_TIM2:    rd_data = card_tim2_r;
      WORD_CARD_TIM3:    rd_data = card_tim3_r;
      WORD_CARD_TIM4:    rd_data = card_tim4_r;
      WORD_CARD_TIM5:    rd_data = card_tim5_r;
      WORD_MODE:         rd_data = mode_r;
      WORD_BOOT:         rd_data = BOOT_WORD_VALUE;
      WORD_ARBITER:      rd_data = arbiter_r;
      WORD_BUF_STR0:     rd_data = buf_str0_r;
      WORD_BUF_STR1:     rd_data = buf_str1_r;
      WORD_LCD_BUF_STR:  rd_data = {{(DataWidth-LcdWidth){1'b0}}, lcd_buf_str_r};
      WORD_LOW_PWR_MODE: rd_data = low_pwr_mode_r;
      WORD_BUF_STR2:     rd_data = buf_str2_r;
      WORD_BUF_STR3:     rd_data = buf_str3_r;
      WORD_COMPANION:    rd_data = {{(DataWidth-CompWidth){1'b0}}, companion_r};
      default:           rd_data = '0;
    endcase
  end

endmodule

// ===== design/memory_controller_register_bank.sv =====
// Top level of the memory controller register bank: access register, decode, result register.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  in_func, in_byte_offset, in_access_bytes,
//                                          in_write_data
//   out_     output     out_valid/out_stall out_read_data, out_ok
//   cfg_     input      cfg_wr_en          cfg_wr_data (soc_is_gen2)
//
// An access is captured in the access register, then decoded and carried out against the
// register file, and its result is held in the result register, from which it is offered;
// one access per cycle is sustained while the output does not stall.
// The rate is set by the combinational decode and read multiplexer between the two registers.
// Reset is synchronous and active low; it restores every word to its reset value.
// A stalled result holds the access register, which then stalls the input.
module memory_controller_register_bank
  import mcrb_pkg::*;
#(
  parameter int unsigned WINDOW_BYTES = WindowBytesDefault
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_func,
  input  logic [OffsetWidth-1:0] in_byte_offset,
  input  logic [SizeWidth-1:0]   in_access_bytes,
  input  logic [DataWidth-1:0]   in_write_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [DataWidth-1:0]   out_read_data,
  output logic                   out_ok,
  input  logic                   cfg_wr_en,
  input  logic                   cfg_wr_data
);

  logic                   gen2_r;
  logic                   s1_valid_r;
  logic                   s1_func_r;
  logic [OffsetWidth-1:0] s1_offset_r;
  logic [SizeWidth-1:0]   s1_size_r;
  logic [DataWidth-1:0]   s1_wdata_r;
  logic                   out_valid_r;
  logic [DataWidth-1:0]   out_data_r;
  logic                   out_ok_r;

  logic                   advance;
  logic                   in_take;
  dec_t                   dec;
  logic [DataWidth-1:0]   rd_data;

  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen2_r <= 1'b0;
    end else if (cfg_wr_en) begin
      gen2_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= in_take || (s1_valid_r && !advance);
      out_valid_r <= advance || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_func_r   <= in_func;
      s1_offset_r <= in_byte_offset;
      s1_size_r   <= in_access_bytes;
      s1_wdata_r  <= in_write_data;
    end
  end

  mcrb_decode #(
    .WINDOW_BYTES(WINDOW_BYTES)
  ) u_decode (
    .func         (s1_func_r),
    .byte_offset  (s1_offset_r),
    .access_bytes (s1_size_r),
    .gen2         (gen2_r),
    .dec          (dec)
  );

  mcrb_regfile u_regfile (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (dec.wr_en && advance),
    .word    (dec.word),
    .wr_data (s1_wdata_r),
    .rd_data (rd_data)
  );

  // Read data is returned only on a successful read; writes and errors give zero.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= (dec.ok && !s1_func_r) ? rd_data : '0;
      out_ok_r   <= dec.ok;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;
  assign out_ok        = out_ok_r;

  a_err_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ok_r) |-> (out_data_r == '0))
    else $error("bus error result carries read data");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled while the pipeline has room");

  a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("advanced access produced no result");

  a_write_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    dec.wr_en |-> (dec.ok && s1_func_r && dec.word != WORD_BOOT))
    else $error("write enable on a rejected access");

endmodule

// ===== tb/tb_memory_controller_register_bank.sv =====
// Self-checking testbench for the memory controller register bank.
`timescale 1ns / 1ps

module tb_memory_controller_register_bank;
  import mcrb_pkg::*;

  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  localparam logic [WordWidth-1:0] WORD_UNMAPPED = 5'd6;
  localparam logic [WordWidth-1:0] WORD_PAST_MAP = WORD_COMPANION + 5'd1;

  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned IDLE_LIMIT    = 1000;
  localparam int unsigned HOLD_AFTER    = 60;
  localparam int unsigned HOLD_CYCLES   = 80;

  typedef struct packed {
    logic                   func;
    logic [OffsetWidth-1:0] offset;
    logic [SizeWidth-1:0]   size;
    logic [DataWidth-1:0]   data;
  } access_t;

  typedef struct packed {
    logic [DataWidth-1:0] read_data;
    logic                 ok;
  } access_result_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_ALTERNATE, STALL_HEAVY} stall_mode_t;

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   in_func = 1'b0;
  logic [OffsetWidth-1:0] in_byte_offset = '0;
  logic [SizeWidth-1:0]   in_access_bytes = '0;
  logic [DataWidth-1:0]   in_write_data = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [DataWidth-1:0]   out_read_data;
  logic                   out_ok;
  logic                   cfg_wr_en = 1'b0;
  logic                   cfg_wr_data = 1'b0;

  access_t        pending_accesses[$];
  access_result_t expected_results[$];

  // Predicted contents of the bank, indexed by word, and the generation select.
  logic [DataWidth-1:0] bank_words[0:31];
  logic                 soc_gen2;
  int unsigned          failures = 0;

  memory_controller_register_bank dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_byte_offset  (in_byte_offset),
    .in_access_bytes (in_access_bytes),
    .in_write_data   (in_write_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_read_data   (out_read_data),
    .out_ok          (out_ok),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Carries out one access against the predicted bank and returns what it should answer.
  function automatic access_result_t bank_access(input access_t acc);
    access_result_t       res;
    logic [WordWidth-1:0] word;
    logic                 present;
    logic                 writable;
    logic [DataWidth-1:0] mask;
    res      = '0;
    word     = acc.offset[WordWidth+1:2];
    present  = 1'b1;
    writable = 1'b1;
    mask     = '1;
    case (word)
      WORD_SDRAM_CFG, WORD_REFRESH_CFG, WORD_STATIC_TIM0, WORD_STATIC_TIM1, WORD_STATIC_TIM2,
      WORD_EXP_CFG, WORD_SYNC_STATIC, WORD_CARD_TIM0, WORD_CARD_TIM1, WORD_CARD_TIM2,
      WORD_CARD_TIM3, WORD_CARD_TIM4, WORD_CARD_TIM5, WORD_MODE, WORD_LOW_PWR_MODE: ;
      WORD_UNDOC: present = soc_gen2;
      WORD_SYNC_MODE: present = !soc_gen2;
      WORD_BOOT: writable = 1'b0;
      WORD_ARBITER: begin
        present = soc_gen2;
        mask    = ARB_WRITE_MASK;
      end
      WORD_BUF_STR0, WORD_BUF_STR1, WORD_BUF_STR2, WORD_BUF_STR3: present = soc_gen2;
      WORD_LCD_BUF_STR: begin
        present = soc_gen2;
        mask    = DataWidth'(LCD_WRITE_MASK);
      end
      WORD_COMPANION: mask = DataWidth'(COMP_WRITE_MASK);
      default: present = 1'b0;
    endcase
    if (acc.size != ACCESS_WORD_BYTES ||
        acc.offset[OffsetWidth-1:2] > (OffsetWidth-2)'(WORD_COMPANION))
      present = 1'b0;
    if (acc.func == FUNC_WRITE && !writable)
      present = 1'b0;
    if (present) begin
      res.ok = 1'b1;
      if (acc.func == FUNC_WRITE)
        bank_words[word] = acc.data & mask;
      else
        res.read_data = bank_words[word];
    end
    return res;
  endfunction

  task automatic push_access(input logic func, input logic [OffsetWidth-3:0] word,
                             input logic [1:0] low, input logic [SizeWidth-1:0] size,
                             input logic [DataWidth-1:0] data);
    access_t acc;
    acc.func   = func;
    acc.offset = {word, low};
    acc.size   = size;
    acc.data   = data;
    pending_accesses.push_back(acc);
  endtask

  // Queues an access to one of the named words at the bottom of the window.
  task automatic push_word(input logic func, input logic [WordWidth-1:0] word,
                           input logic [1:0] low, input logic [SizeWidth-1:0] size,
                           input logic [DataWidth-1:0] data);
    push_access(func, {{(OffsetWidth-2-WordWidth){1'b0}}, word}, low, size, data);
  endtask

  // Mostly well-formed word accesses to the mapped range, with some bad sizes and stray offsets.
  task automatic queue_random(input int unsigned count);
    logic [OffsetWidth-3:0] word;
    logic [SizeWidth-1:0]   size;
    logic [DataWidth-1:0]   data;
    repeat (count) begin
      if ($urandom_range(0, 9) < 8)
        size = ACCESS_WORD_BYTES;
      else
        size = SizeWidth'($urandom_range(0, 15));
      if ($urandom_range(0, 9) == 0)
        word = (OffsetWidth-2)'($urandom);
      else
        word = (OffsetWidth-2)'($urandom_range(0, WORD_COMPANION + 2));
      case ($urandom_range(0, 9))
        0: data = '0;
        1: data = '1;
        default: data = $urandom;
      endcase
      push_access(1'($urandom), word, 2'($urandom), size, data);
    end
  endtask

  // Waits until every queued access has been taken and answered, then lets the pipeline settle.
  // The check is made between edges, once the sender's outputs for the last edge have settled.
  task automatic wait_for_drain();
    while (pending_accesses.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_gen_select(input logic gen2);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= gen2;
    soc_gen2 = gen2;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    for (int i = 0; i < 32; i++) bank_words[i] = '0;
    bank_words[WORD_SDRAM_CFG]   = SDRAM_CFG_RESET;
    bank_words[WORD_REFRESH_CFG] = REFRESH_CFG_RESET;
    bank_words[WORD_STATIC_TIM0] = STATIC_TIM_RESET;
    bank_words[WORD_STATIC_TIM1] = STATIC_TIM_RESET;
    bank_words[WORD_STATIC_TIM2] = STATIC_TIM_RESET;
    bank_words[WORD_SYNC_STATIC] = SYNC_STATIC_RESET;
    bank_words[WORD_MODE]        = MODE_RESET;
    bank_words[WORD_BOOT]        = BOOT_WORD_VALUE;
    bank_words[WORD_ARBITER]     = ARBITER_RESET;
    bank_words[WORD_BUF_STR0]    = BUF_STR_RESET;
    bank_words[WORD_BUF_STR1]    = BUF_STR_RESET;
    bank_words[WORD_BUF_STR2]    = BUF_STR_RESET;
    bank_words[WORD_BUF_STR3]    = BUF_STR_RESET;
    bank_words[WORD_LCD_BUF_STR] = DataWidth'(LCD_BUF_STR_RESET);
    soc_gen2 = 1'b0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // First generation: reset values, size errors, boot word, masks and missing words.
    push_word(FUNC_READ, WORD_SDRAM_CFG, 2'b00, ACCESS_WORD_BYTES, '0);
    push_word(FUNC_READ, WORD_REFRESH_CFG, 2'b00, ACCESS_WORD_BYTES, '0);
    push_word(FUNC_READ, WORD_MODE, 2'b01, ACCESS_WORD_BYTES, '0);
    push_word(FUNC_READ, WORD_ARBITER, 2'b00, ACCESS_WORD_BYTES, '0);
    push_word(FUNC_WRITE, WORD_SDRAM_CFG, 2'b00, ACCESS_WORD_BYTES, '1);
    push_word(FUNC_READ, WORD_SDRAM_CFG, 2'b10, ACCESS_WORD_BYTES, '0);
    push_word(FUNC_READ, WORD_BOOT, 2'b00, ACCESS_WORD_BYTES, '0);
    push_word(FUNC_WRITE, WORD_BOOT, 2'b00, ACCESS_WORD_BYTES, '1);
    push_word(FUNC_READ, WORD_SDRAM_CFG, 2'b00, 4'd0, '0);
    push_word(FUNC_WRITE, WORD_SDRAM_CFG, 2'b00, 4'hf, '0);
    push_word(FUNC_READ, WORD_SDRAM_CFG, 2'b00, 4'd8, '0);
    push_word(FUNC_READ, WORD_SDRAM_CFG, 2'b00, 4'd1, '0);
    push_word(FUNC_WRITE, WORD_COMPANION, 2'b11, ACCESS_WORD_BYTES, '1);
    push_word(FUNC_READ, WORD_COMPANION, 2'b00, ACCESS_WORD_BYTES, '0);
    push_word(FUNC_READ, WORD_UNMAPPED, 2'b00, ACCESS_WORD_BYTES, '0);
    push_word(FUNC_READ, WORD_PAST_MAP, 2'b00, ACCESS_WORD_BYTES, '0);
    push_access(FUNC_READ, '1, 2'b11, ACCESS_WORD_BYTES, '0);
    push_word(FUNC_WRITE, WORD_SYNC_MODE, 2'b00, ACCESS_WORD_BYTES, 32'ha5a5_5a5a);
    push_word(FUNC_READ, WORD_UNDOC, 2'b00, ACCESS_WORD_BYTES, '0);
    queue_random(250);
    wait_for_drain();

    write_gen_select(1'b1);
    // Second generation: masked writes and the words that only it has.
    push_word(FUNC_WRITE, WORD_ARBITER, 2'b00, ACCESS_WORD_BYTES, '1);
    push_word(FUNC_READ, WORD_ARBITER, 2'b00, ACCESS_WORD_BYTES, '0);
    push_word(FUNC_WRITE, WORD_LCD_BUF_STR, 2'b00, ACCESS_WORD_BYTES, '1);
    push_word(FUNC_READ, WORD_LCD_BUF_STR, 2'b00, ACCESS_WORD_BYTES, '0);
    push_word(FUNC_READ, WORD_BUF_STR3, 2'b00, ACCESS_WORD_BYTES, '0);
    push_word(FUNC_READ, WORD_SYNC_MODE, 2'b00, ACCESS_WORD_BYTES, '0);
    push_word(FUNC_WRITE, WORD_UNDOC, 2'b00, ACCESS_WORD_BYTES, 32'h1234_5678);
    push_word(FUNC_READ, WORD_UNDOC, 2'b00, ACCESS_WORD_BYTES, '0);
    queue_random(250);
    wait_for_drain();

    write_gen_select(1'b0);
    queue_random(100);
    wait_for_drain();

    write_gen_select(1'b1);
    queue_random(100);
    wait_for_drain();

    if (failures == 0)
      $display("PASS memory_controller_register_bank");
    else
      $display("FAIL memory_controller_register_bank");
    $finish;
  end

  // Sender: bursts of random length separated by random gaps; a stalled transfer is held.
  always @(posedge clk) begin : sender
    access_t     offered;
    int unsigned burst_left;
    int unsigned gap_left;
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_valid && !in_stall)
        expected_results.push_back(bank_access(offered));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_accesses.size() > 0) begin
          offered = pending_accesses.pop_front();
          in_valid        <= 1'b1;
          in_func         <= offered.func;
          in_byte_offset  <= offered.offset;
          in_access_bytes <= offered.size;
          in_write_data   <= offered.data;
          if (burst_left == 0)
            burst_left = $urandom_range(1, 40);
          burst_left--;
          if (burst_left == 0) begin
            case ($urandom_range(0, 5))
              0, 1: gap_left = 0;
              2: gap_left = $urandom_range(13, 30);
              default: gap_left = $urandom_range(1, 6);
            endcase
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: switches between stall patterns, with one long hold-off early in the run.
  always @(posedge clk) begin : receiver
    stall_mode_t stall_mode;
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned results_taken;
    bit          hold_done;
    if (!rst_n) begin
      out_stall <= 1'b0;
      mode_left     = 0;
      hold_left     = 0;
      results_taken = 0;
      hold_done     = 1'b0;
      stall_mode    = STALL_NONE;
    end else begin
      if (out_valid && !out_stall)
        results_taken++;
      if (!hold_done && results_taken >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = stall_mode_t'($urandom_range(0, 3));
          mode_left  = $urandom_range(16, 64);
        end
        mode_left--;
        case (stall_mode)
          STALL_NONE: out_stall <= 1'b0;
          STALL_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
          STALL_ALTERNATE: out_stall <= !out_stall;
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Each result transfer is checked against the oldest outstanding prediction.
  always @(posedge clk) begin : result_check
    access_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: read_data %h, ok %b", out_read_data, out_ok);
        failures++;
      end else begin
        want = expected_results.pop_front();
        if (out_read_data !== want.read_data) begin
          $error("read_data: expected %h, got %h", want.read_data, out_read_data);
          failures++;
        end
        if (out_ok !== want.ok) begin
          $error("ok: expected %b, got %b", want.ok, out_ok);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    int unsigned idle_cycles;
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL memory_controller_register_bank");
      $finish;
    end
  end

endmodule
